// ===== rtl/core/ilsc_pkg.sv =====
// Shared types, operation codes and status codes for the indexed list block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package ilsc_pkg;

  // Default list capacity in entries.
  localparam int CAPACITY_DEF = 64;

  // Operation selector carried on the input tuser.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Result status carried on the output tuser.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Per-cycle move applied by every storage cell.
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_REM  = 2'd2;

  // Sign class of an entry.
  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_NEG  = 2'd1;
  localparam logic [1:0] CLS_POS  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } cell_ctl_t;

  function automatic logic [1:0] sign_class(input logic [31:0] v);
    logic [1:0] cls;
    if (v == 32'd0) begin
      cls = CLS_ZERO;
    end else if (v[31]) begin
      cls = CLS_NEG;
    end else begin
      cls = CLS_POS;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ilsc_cell.sv =====
// One storage cell of the list: holds one slot and moves with its neighbors.
// Depends on ilsc_pkg for the cell control struct and move codes.
`default_nettype none

module ilsc_cell #(
  parameter int CW  = 7,
  parameter int POS = 0
) (
  input  logic              clk,
  input  ilsc_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]     idx,
  input  logic [31:0]       left_data,
  input  logic [31:0]       right_data,
  output logic [31:0]       data,
  output logic [31:0]       hit_data
);
  import ilsc_pkg::*;

  localparam logic [CW-1:0] MY_POS = CW'(POS);

  logic [31:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctl.op)
      CELL_INS: begin
        if (MY_POS > idx) begin
          data_next = left_data;
        end else if (MY_POS == idx) begin
          data_next = ctl.value;
        end
      end
      CELL_REM: begin
        if (MY_POS >= idx) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Only the addressed cell drives its entry onto the gather tree.
  assign hit_data = (MY_POS == idx) ? data : 32'd0;

endmodule

`default_nettype wire

// ===== rtl/core/ilsc_gather.sv =====
// Two-level registered OR tree that collects the addressed cell's entry.
// Depends on ilsc_pkg only by convention; all widths come from parameters.
`default_nettype none

module ilsc_gather #(
  parameter int N     = 64,
  parameter int GROUP = 8
) (
  input  logic        clk,
  input  logic [31:0] hits [N],
  output logic [31:0] sel_data
);
  import ilsc_pkg::*;

  localparam int NG = (N + GROUP - 1) / GROUP;

  logic [31:0] padded   [NG*GROUP];
  logic [31:0] grp      [NG];
  logic [31:0] grp_next [NG];
  logic [31:0] sel_next;

  for (genvar j = 0; j < NG * GROUP; j++) begin : g_pad
    if (j < N) begin : g_real
      assign padded[j] = hits[j];
    end else begin : g_zero
      assign padded[j] = 32'd0;
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = 32'd0;
      for (int k = 0; k < GROUP; k++) begin
        grp_next[g] = grp_next[g] | padded[g*GROUP + k];
      end
    end
  end

  always_comb begin
    sel_next = 32'd0;
    for (int g = 0; g < NG; g++) begin
      sel_next = sel_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    grp      <= grp_next;
    sel_data <= sel_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_with_sign_counts_top.sv =====
// An accepted input transaction passes through the states TREE1, TREE2 and COMMIT, and its
// result is registered on the output at commit; COMMIT waits while the previous result is still
// waiting. A new transaction is accepted only in IDLE, after the last one commits: TREE1 and
// TREE2 let the two registered levels of the gather tree fetch the addressed entry before the
// cell chain shifts. Reset clears the length, the sign counters, the control state and the
// output valid; slot contents are not cleared and are never read unwritten.
// Top level of the indexed list: cell chain, gather tree, sign counters, output register.
// Depends on ilsc_pkg, ilsc_cell and ilsc_gather.
`default_nettype none

module indexed_list_with_sign_counts_top #(
  parameter int CAPACITY = ilsc_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int IN_W     = ((CW + 32 + 7) / 8) * 8,
  parameter int OUT_W    = ((32 + 4 * CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [1:0]       s_tuser,   // [1:0] func
  input  logic [IN_W-1:0]  s_tdata,   // index, value, zero fill
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [1:0]       m_tuser,   // [1:0] status
  output logic [OUT_W-1:0] m_tdata    // read_value, length, negative_count,
                                      // positive_count, zero_count, zero fill
);
  import ilsc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_TREE1  = 2'd1;
  localparam logic [1:0] S_TREE2  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE     = CW'(1);

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [1:0]    op_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   val_r;
  logic [1:0]    status_r;
  logic [1:0]    status_next;

  logic [CW-1:0] count, neg, pos, zer;
  logic [CW-1:0] count_next, neg_next, pos_next, zer_next;

  logic          in_fire;
  logic          commit;
  logic [1:0]    in_func;
  logic [CW-1:0] in_idx;
  logic [31:0]   in_val;
  logic [31:0]   sel_data;
  logic [31:0]   rd_value;
  logic [1:0]    cls;

  logic [1:0]    m_status;
  logic [31:0]   m_rd;
  logic [CW-1:0] m_len, m_neg, m_pos, m_zer;

  cell_ctl_t     ctl;
  logic [31:0]   cell_data [CAPACITY];
  logic [31:0]   hits      [CAPACITY];

  assign in_func  = s_tuser;
  assign in_idx   = s_tdata[CW-1:0];
  assign in_val   = s_tdata[CW+31:CW];
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign commit   = (state == S_COMMIT) && (!m_tvalid || m_tready);

  // Status is settled at acceptance from the length before the operation.
  always_comb begin
    status_next = ST_DONE;
    unique case (in_func)
      OP_INSERT: begin
        if (in_idx > count) begin
          status_next = ST_RANGE;
        end else if (count == CAP_CNT) begin
          status_next = ST_FULL;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (in_idx >= count) begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_fire) state_next = S_TREE1;
      S_TREE1:  state_next = S_TREE2;
      S_TREE2:  state_next = S_COMMIT;
      S_COMMIT: if (commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_func;
      idx_r    <= in_idx;
      val_r    <= in_val;
      status_r <= status_next;
    end
  end

  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.value = val_r;
    if (commit && status_r == ST_DONE) begin
      if (op_r == OP_INSERT) begin
        ctl.op = CELL_INS;
      end else if (op_r == OP_REMOVE) begin
        ctl.op = CELL_REM;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_in;
    logic [31:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = 32'd0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = 32'd0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    ilsc_cell #(.CW(CW), .POS(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (idx_r),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .hit_data   (hits[i])
    );
  end

  ilsc_gather #(.N(CAPACITY), .GROUP(8)) u_gather (
    .clk      (clk),
    .hits     (hits),
    .sel_data (sel_data)
  );

  // An insert adds the class of the new value; a remove drops the class of the
  // entry that the gather tree fetched before the chain shifted.
  always_comb begin
    count_next = count;
    neg_next   = neg;
    pos_next   = pos;
    zer_next   = zer;
    cls        = (op_r == OP_INSERT) ? sign_class(val_r) : sign_class(sel_data);
    if (status_r == ST_DONE && op_r == OP_INSERT) begin
      count_next = count + ONE;
      unique case (cls)
        CLS_NEG: neg_next = neg + ONE;
        CLS_POS: pos_next = pos + ONE;
        default: zer_next = zer + ONE;
      endcase
    end else if (status_r == ST_DONE && op_r == OP_REMOVE) begin
      count_next = count - ONE;
      unique case (cls)
        CLS_NEG: neg_next = neg - ONE;
        CLS_POS: pos_next = pos - ONE;
        default: zer_next = zer - ONE;
      endcase
    end
  end

  assign rd_value = (op_r == OP_READ && status_r == ST_DONE) ? sel_data : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      neg   <= '0;
      pos   <= '0;
      zer   <= '0;
    end else if (commit) begin
      count <= count_next;
      neg   <= neg_next;
      pos   <= pos_next;
      zer   <= zer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_status <= status_r;
      m_rd     <= rd_value;
      m_len    <= count_next;
      m_neg    <= neg_next;
      m_pos    <= pos_next;
      m_zer    <= zer_next;
    end
  end

  assign m_tuser = m_status;
  assign m_tdata = OUT_W'({m_zer, m_pos, m_neg, m_len, m_rd});

endmodule

`default_nettype wire

// ===== rtl/core/ilsc_checker.sv =====
// Port-level checker for the indexed list top level, attached by bind.
// Depends on ilsc_pkg for status codes and on the top level's port widths.
`default_nettype none

module ilsc_checker #(
  parameter int CAPACITY = ilsc_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int OUT_W    = ((32 + 4 * CW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [1:0]       m_tuser,
  input logic [OUT_W-1:0] m_tdata
);
  import ilsc_pkg::*;

  logic [CW+1:0] sign_sum;
  logic [CW+1:0] len_ext;

  assign sign_sum = {2'b00, m_tdata[32+2*CW-1:32+CW]}
                  + {2'b00, m_tdata[32+3*CW-1:32+2*CW]}
                  + {2'b00, m_tdata[32+4*CW-1:32+3*CW]};
  assign len_ext  = {2'b00, m_tdata[32+CW-1:32]};

  // The three sign counters always add up to the length.
  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (sign_sum == len_ext))
    else $error("sign counts do not add up to the length");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_DONE || m_tuser == ST_RANGE || m_tuser == ST_FULL))
    else $error("unknown status code");

  // One transaction at a time: input is held off right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction is in flight");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
    else $error("result appeared without a matching input four cycles earlier");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind indexed_list_with_sign_counts_top ilsc_checker #(
  .CAPACITY (CAPACITY),
  .CW       (CW),
  .OUT_W    (OUT_W)
) u_ilsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

`default_nettype wire
